/* rtl/core/htd_pkg.sv */
// ----------------------------------------------------------------------------
// htd_pkg
// Types and constants shared by the Huffman table decoder.
// ----------------------------------------------------------------------------
package htd_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_READ,
    ST_CMP,
    ST_FIN
  } state_e;

  localparam int unsigned CodeW = 32;
  localparam int unsigned LenW  = 6;
  localparam int unsigned SymW  = 8;

  localparam logic [SymW-1:0] EscNewline = 8'h24;
  localparam logic [SymW-1:0] EscSpace   = 8'h5E;
  localparam logic [SymW-1:0] ChrNewline = 8'h0A;
  localparam logic [SymW-1:0] ChrSpace   = 8'h20;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [7:0]      entry_index;
    logic [CodeW-1:0] entry_code;
    logic [LenW-1:0] entry_length;
    logic [SymW-1:0] entry_symbol;
    logic [7:0]      data_byte;
  } in_t;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            overflow;
    logic            last;
  } out_t;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  length;
    logic [SymW-1:0]  symbol;
  } entry_t;

  function automatic logic [SymW-1:0] map_symbol(input logic [SymW-1:0] s);
    logic [SymW-1:0] r;
    r = s;
    if (s == EscNewline) r = ChrNewline;
    else if (s == EscSpace) r = ChrSpace;
    return r;
  endfunction

endpackage

/* rtl/core/htd_table.sv */
// ----------------------------------------------------------------------------
// htd_table
// Code table memory with one write and one registered read port, plus
// per-entry valid bits cleared at once.
// ----------------------------------------------------------------------------
module htd_table #(
  parameter int unsigned Entries = 256,
  parameter int unsigned IdxW    = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [IdxW-1:0]   waddr_i,
  input  htd_pkg::entry_t   wdata_i,
  input  logic              clr_i,
  input  logic [IdxW-1:0]   raddr_i,
  output htd_pkg::entry_t   rdata_o,
  output logic              rvalid_o
);

  htd_pkg::entry_t mem [Entries];
  logic [Entries-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_o <= 1'b0;
    end else begin
      if (clr_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_o <= valid_q[raddr_i];
    end
  end

endmodule

/* rtl/core/huffman_table_decoder_top.sv */
// ----------------------------------------------------------------------------
// huffman_table_decoder_top
// Table-driven Huffman bit-stream decoder.
// ----------------------------------------------------------------------------
// A data byte is shifted in one bit at a time; after each bit the code table
// memory is scanned from the highest entry down, each entry being read and
// then compared, stopping at the first match; load and clear items are
// taken without a scan. Results appear on strobe_o for one cycle each and
// cannot be stalled; busy stays high until the last result of a byte has
// been driven.
module huffman_table_decoder_top #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  htd_pkg::in_t  in_i,
  output logic          strobe_o,
  output htd_pkg::out_t result_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned PLenW = $clog2(MAX_CODE_BITS + 1);
  localparam int unsigned CmpW = (PLenW > htd_pkg::LenW) ? PLenW : htd_pkg::LenW;
  localparam logic [IdxW-1:0] TopIdx = IdxW'(TABLE_ENTRIES - 1);
  localparam logic [PLenW-1:0] MaxLen = PLenW'(MAX_CODE_BITS);

  htd_pkg::state_e state_q, state_d;
  logic [7:0] data_q, data_d;
  logic [2:0] bit_q, bit_d;
  logic [MAX_CODE_BITS-1:0] pcode_q, pcode_d;
  logic [PLenW-1:0] plen_q, plen_d;
  logic [IdxW-1:0] addr_q, addr_d;
  logic pend_vld_q, pend_vld_d;
  logic [htd_pkg::SymW-1:0] pend_sym_q, pend_sym_d;
  logic pend_ovf_q, pend_ovf_d;
  logic strobe_q, strobe_d;
  htd_pkg::out_t res_q, res_d;

  logic accept, we, clr;
  htd_pkg::entry_t wdata, rdata;
  logic rvalid;
  logic [MAX_CODE_BITS-1:0] code_ext, mask;
  logic len_eq, hit;
  logic new_res, new_ovf, bit_done;
  logic [htd_pkg::SymW-1:0] new_sym;

  assign accept = start && !busy;
  assign we = accept && (in_i.cmd == htd_pkg::CMD_LOAD) &&
              ({1'b0, in_i.entry_index} < 9'(TABLE_ENTRIES));
  assign clr = accept && (in_i.cmd == htd_pkg::CMD_CLEAR);
  assign wdata = '{code: in_i.entry_code, length: in_i.entry_length,
                   symbol: in_i.entry_symbol};

  htd_table #(.Entries(TABLE_ENTRIES), .IdxW(IdxW)) u_table (
    .clk_i,
    .rst_ni,
    .we_i    (we),
    .waddr_i (in_i.entry_index[IdxW-1:0]),
    .wdata_i (wdata),
    .clr_i   (clr),
    .raddr_i (addr_q),
    .rdata_o (rdata),
    .rvalid_o(rvalid)
  );

  always_comb begin
    code_ext = MAX_CODE_BITS'({{MAX_CODE_BITS{1'b0}}, rdata.code});
    if (CmpW'(rdata.length) >= CmpW'(MAX_CODE_BITS)) begin
      mask = '1;
    end else begin
      mask = ~({MAX_CODE_BITS{1'b1}} << rdata.length);
    end
    len_eq = (CmpW'(rdata.length) == CmpW'(plen_q));
    hit = rvalid && len_eq && ((code_ext & mask) == pcode_q);
  end

  always_comb begin
    state_d = state_q;
    data_d = data_q;
    bit_d = bit_q;
    pcode_d = pcode_q;
    plen_d = plen_q;
    addr_d = addr_q;
    pend_vld_d = pend_vld_q;
    pend_sym_d = pend_sym_q;
    pend_ovf_d = pend_ovf_q;
    strobe_d = 1'b0;
    res_d = res_q;
    new_res = 1'b0;
    new_ovf = 1'b0;
    new_sym = '0;
    bit_done = 1'b0;
    case (state_q)
      htd_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_i.cmd)
            htd_pkg::CMD_DATA: begin
              data_d = in_i.data_byte;
              bit_d = 3'd7;
              state_d = htd_pkg::ST_SHIFT;
            end
            htd_pkg::CMD_CLEAR: begin
              pcode_d = '0;
              plen_d = '0;
            end
            default: ;
          endcase
        end
      end
      htd_pkg::ST_SHIFT: begin
        pcode_d = {pcode_q[MAX_CODE_BITS-2:0], data_q[bit_q]};
        plen_d = plen_q + PLenW'(1);
        addr_d = TopIdx;
        state_d = htd_pkg::ST_READ;
      end
      htd_pkg::ST_READ: begin
        state_d = htd_pkg::ST_CMP;
      end
      htd_pkg::ST_CMP: begin
        if (hit) begin
          new_res = 1'b1;
          new_sym = htd_pkg::map_symbol(rdata.symbol);
          bit_done = 1'b1;
        end else if (addr_q == '0) begin
          if (plen_q == MaxLen) begin
            new_res = 1'b1;
            new_ovf = 1'b1;
          end
          bit_done = 1'b1;
        end else begin
          addr_d = addr_q - IdxW'(1);
          state_d = htd_pkg::ST_READ;
        end
        if (new_res) begin
          pcode_d = '0;
          plen_d = '0;
          if (pend_vld_q) begin
            strobe_d = 1'b1;
            res_d = '{symbol: pend_sym_q, overflow: pend_ovf_q, last: 1'b0};
          end
          pend_vld_d = 1'b1;
          pend_sym_d = new_sym;
          pend_ovf_d = new_ovf;
        end
        if (bit_done) begin
          if (bit_q == 3'd0) begin
            state_d = htd_pkg::ST_FIN;
          end else begin
            bit_d = bit_q - 3'd1;
            state_d = htd_pkg::ST_SHIFT;
          end
        end
      end
      htd_pkg::ST_FIN: begin
        if (pend_vld_q) begin
          strobe_d = 1'b1;
          res_d = '{symbol: pend_sym_q, overflow: pend_ovf_q, last: 1'b1};
        end
        pend_vld_d = 1'b0;
        state_d = htd_pkg::ST_IDLE;
      end
      default: state_d = htd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= htd_pkg::ST_IDLE;
      bit_q <= '0;
      pcode_q <= '0;
      plen_q <= '0;
      addr_q <= '0;
      pend_vld_q <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q <= state_d;
      bit_q <= bit_d;
      pcode_q <= pcode_d;
      plen_q <= plen_d;
      addr_q <= addr_d;
      pend_vld_q <= pend_vld_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    pend_sym_q <= pend_sym_d;
    pend_ovf_q <= pend_ovf_d;
    res_q <= res_d;
  end

  assign busy = (state_q != htd_pkg::ST_IDLE);
  assign strobe_o = strobe_q;
  assign result_o = res_q;

endmodule

/* sim/htd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htd_checker
// Watches the command and result channels of the Huffman table decoder,
// keeps its own copy of the code table and partial code, and compares every
// result transfer against the oldest predicted symbol or overflow.
// ----------------------------------------------------------------------------
module htd_checker #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  htd_pkg::in_t  in_i,
  input  logic          strobe_i,
  input  htd_pkg::out_t result_i,
  output int            errors_o,
  output int            pending_o,
  output int            symbols_o,
  output int            overflows_o
);

  logic [htd_pkg::CodeW-1:0] tbl_code [TABLE_ENTRIES];
  logic [htd_pkg::LenW-1:0]  tbl_len  [TABLE_ENTRIES];
  logic [htd_pkg::SymW-1:0]  tbl_sym  [TABLE_ENTRIES];
  logic                      tbl_vld  [TABLE_ENTRIES] = '{default: 1'b0};
  logic [63:0]               part_code = '0;
  int unsigned               part_len = 0;
  htd_pkg::out_t             expected_q [$];
  int                        n_err = 0;
  int                        n_sym = 0;
  int                        n_ovf = 0;

  assign errors_o    = n_err;
  assign symbols_o   = n_sym;
  assign overflows_o = n_ovf;
  assign pending_o   = expected_q.size();

  function automatic logic [htd_pkg::SymW-1:0] escape_map(
      input logic [htd_pkg::SymW-1:0] s);
    if (s == htd_pkg::EscNewline) return htd_pkg::ChrNewline;
    if (s == htd_pkg::EscSpace) return htd_pkg::ChrSpace;
    return s;
  endfunction

  task automatic decode_item(input htd_pkg::in_t x);
    int            hit;
    int            first;
    htd_pkg::out_t r;
    logic [63:0]   mask;
    first = expected_q.size();
    case (htd_pkg::cmd_e'(x.cmd))
      htd_pkg::CMD_LOAD: begin
        if (x.entry_index < TABLE_ENTRIES) begin
          tbl_code[x.entry_index] = x.entry_code;
          tbl_len[x.entry_index]  = x.entry_length;
          tbl_sym[x.entry_index]  = x.entry_symbol;
          tbl_vld[x.entry_index]  = 1'b1;
        end
      end
      htd_pkg::CMD_CLEAR: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) tbl_vld[i] = 1'b0;
        part_code = '0;
        part_len  = 0;
      end
      htd_pkg::CMD_DATA: begin
        for (int b = 7; b >= 0; b--) begin
          part_code = ((part_code << 1) | 64'(x.data_byte[b]))
                      & ((64'd1 << MAX_CODE_BITS) - 64'd1);
          part_len++;
          hit = -1;
          for (int i = TABLE_ENTRIES - 1; i >= 0 && hit < 0; i--) begin
            if (tbl_vld[i] && tbl_len[i] != 0 && tbl_len[i] <= MAX_CODE_BITS
                && tbl_len[i] == part_len) begin
              mask = (64'd1 << tbl_len[i]) - 64'd1;
              if ((64'(tbl_code[i]) & mask) == part_code) hit = i;
            end
          end
          if (hit >= 0) begin
            r.symbol = escape_map(tbl_sym[hit]);
            r.overflow = 1'b0;
            r.last = 1'b0;
            expected_q.push_back(r);
            part_code = '0;
            part_len  = 0;
          end else if (part_len >= MAX_CODE_BITS) begin
            r = '0;
            r.overflow = 1'b1;
            expected_q.push_back(r);
            part_code = '0;
            part_len  = 0;
          end
        end
        if (expected_q.size() > first) expected_q[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (strobe_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result expected none actual %h", $time, result_i);
          n_err++;
        end else begin
          if (result_i.symbol !== expected_q[0].symbol ||
              result_i.overflow !== expected_q[0].overflow ||
              result_i.last !== expected_q[0].last) begin
            $display("%0t: mismatch expected sym=%h ovf=%b last=%b",
                     $time, expected_q[0].symbol, expected_q[0].overflow,
                     expected_q[0].last);
            $display("%0t:          actual   sym=%h ovf=%b last=%b",
                     $time, result_i.symbol, result_i.overflow, result_i.last);
            n_err++;
          end
          if (expected_q[0].overflow) n_ovf++;
          else n_sym++;
          void'(expected_q.pop_front());
        end
      end
      if (start_i && !busy_i) decode_item(in_i);
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the Huffman table decoder: directed escape,
// priority, length and overflow cases, then random prefix-code tables with
// random data bytes, noise loads and unknown commands, with random gaps.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned NumItems = 230;
  localparam longint     Limit    = 64'd4_000_000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  htd_pkg::in_t  in_d = '0;
  logic          strobe_o;
  htd_pkg::out_t result_o;
  int            errors, pending, n_sym, n_ovf;
  int            sent = 0;
  bit            no_gaps = 0;
  longint        cycles = 0;

  always #2 clk_i = ~clk_i;

  huffman_table_decoder_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .in_i(in_d), .strobe_o(strobe_o), .result_o(result_o)
  );

  htd_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy),
    .in_i(in_d), .strobe_i(strobe_o), .result_i(result_o),
    .errors_o(errors), .pending_o(pending), .symbols_o(n_sym),
    .overflows_o(n_ovf)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic htd_pkg::in_t rand_item(input htd_pkg::cmd_e c);
    htd_pkg::in_t x;
    x = {$urandom, $urandom};
    x.cmd = c;
    return x;
  endfunction

  task automatic send(input htd_pkg::in_t x);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    in_d  <= x;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic load(input int idx, input logic [31:0] code, input int len,
                      input logic [7:0] sym);
    htd_pkg::in_t x;
    x = rand_item(htd_pkg::CMD_LOAD);
    x.entry_index  = 8'(idx);
    x.entry_code   = code;
    x.entry_length = 6'(len);
    x.entry_symbol = sym;
    send(x);
  endtask

  task automatic data(input logic [7:0] b);
    htd_pkg::in_t x;
    x = rand_item(htd_pkg::CMD_DATA);
    x.data_byte = b;
    send(x);
  endtask

  initial begin
    int len, n, base;
    logic [31:0] c;
    logic [31:0] m;
    logic [7:0] s;
    htd_pkg::in_t x;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // priority, upper code bits ignored, escapes, unusable lengths
    send(rand_item(htd_pkg::CMD_CLEAR));
    load(255, 32'h1, 1, 8'h41);
    load(3, 32'hFFFF_FFFF, 1, 8'h42);
    load(10, 32'hFFFF_FFF0, 2, htd_pkg::EscNewline);
    load(11, 32'h0000_0001, 2, htd_pkg::EscSpace);
    load(12, 32'h0, 0, 8'h00);
    load(13, 32'h0, 63, 8'hFF);
    data(8'hFF);
    data(8'h00);
    data(8'h55);
    send(rand_item(htd_pkg::CMD_NONE));
    // full-length code and overflow
    send(rand_item(htd_pkg::CMD_CLEAR));
    load(0, 32'hFFFF_FFFF, 32, 8'hFF);
    repeat (4) data(8'hFF);
    repeat (4) data(8'h00);
    send(rand_item(htd_pkg::CMD_CLEAR));
    repeat (4) data(8'hA5);

    while (sent < NumItems) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) send(rand_item(htd_pkg::CMD_CLEAR));
      len  = $urandom_range(1, 6);
      n    = (len <= 4) ? (1 << len) : 12;
      base = $urandom_range(0, 255);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 7) == 0 && len <= 4) continue;
        c = $urandom;
        if (len <= 4) begin
          m = (32'd1 << len) - 32'd1;
          c = (c & ~m) | (32'(i) & m);
        end
        case ($urandom_range(0, 7))
          0: s = htd_pkg::EscNewline;
          1: s = htd_pkg::EscSpace;
          default: s = 8'($urandom);
        endcase
        load((base + i * 7) % 256, c, len, s);
      end
      if ($urandom_range(0, 2) == 0) begin
        x = rand_item(htd_pkg::CMD_LOAD);
        x.entry_length = 6'($urandom_range(0, 63));
        send(x);
      end
      n = $urandom_range(6, 16);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 15))
          0: send(rand_item(htd_pkg::CMD_NONE));
          1: send(rand_item(htd_pkg::cmd_e'($urandom_range(0, 3))));
          default: data(8'($urandom));
        endcase
      end
      if (sent > NumItems / 2 && sent < NumItems / 2 + 40) begin
        start <= 1'b0;
        @(negedge clk_i);
        while (pending != 0) @(negedge clk_i);
      end
    end
    start <= 1'b0;

    while (pending != 0 || busy) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    $display("Covered %0d transfers: %0d symbols and %0d overflows checked.",
             sent, n_sym, n_ovf);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/htd_pkg.sv
rtl/core/htd_table.sv
rtl/core/huffman_table_decoder_top.sv
sim/htd_checker.sv
sim/tb_top.sv
